[design/fspd_pkg.sv]
// Shared types, constants and lane setup for the force sensor frame pair decoder.
package fspd_pkg;

  localparam int LANES       = 8;   // one lane per payload byte position
  localparam int HDR_BYTES   = 4;   // header bytes checked in the first frame
  localparam int SUM_BYTES2  = 6;   // second-frame bytes that enter the checksum
  localparam logic [3:0] FRAME_LEN = 4'd8;

  // header AA 07 08 0A, byte 0 at index 0
  localparam logic [HDR_BYTES-1:0][7:0] HDR = {8'h0A, 8'h08, 8'h07, 8'hAA};

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_BAD_LEN   = 3'd1,
    RES_COMPLETE  = 3'd2,
    RES_BAD_HDR   = 3'd3,
    RES_BAD_SUM   = 3'd4
  } fspd_code_t;

  typedef struct packed {
    logic       func;
    logic [3:0] frame_length;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;
  } fspd_frame_t;

  typedef struct packed {
    fspd_code_t         result_code;
    logic               packet_ready;
    logic [15:0]        sample_count;
    logic [2:0]         sensor_index;
    logic               several_sensors;
    logic [5:0]         overload_bits;
    logic [2:0]         sensor_fault;
    logic [2:0]         acquisition_fault;
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic signed [15:0] force_z;
  } fspd_result_t;

  // per-lane setup, fixed by byte position
  typedef struct packed {
    logic       add_frame;
    logic       check_hdr;
    logic [7:0] hdr_byte;
  } fspd_lane_cfg_t;

  // what one lane reports to the merge stage
  typedef struct packed {
    logic [8:0] pair_sum;
    logic       hdr_ok;
  } fspd_lane_t;

  // state updates decided by the merge stage
  typedef struct packed {
    logic restart;
    logic store_first;
    logic set_complete;
  } fspd_ctrl_t;

  function automatic fspd_lane_cfg_t lane_cfg(input int idx);
    fspd_lane_cfg_t c;
    c.add_frame = (idx < SUM_BYTES2);
    c.check_hdr = (idx < HDR_BYTES);
    c.hdr_byte  = HDR[idx[1:0]];
    return c;
  endfunction

endpackage

[design/fspd_lane.sv]
// One byte lane: partial checksum of a stored/new byte pair and header compare.
module fspd_lane
  import fspd_pkg::*;
(
  input  fspd_lane_cfg_t cfg,
  input  logic [7:0]     stored_byte,
  input  logic [7:0]     frame_byte,
  output fspd_lane_t     lane
);

  assign lane.pair_sum = {1'b0, stored_byte} + (cfg.add_frame ? {1'b0, frame_byte} : 9'd0);
  assign lane.hdr_ok   = !cfg.check_hdr || (frame_byte == cfg.hdr_byte);

endmodule

[design/fspd_merge.sv]
// Merge stage: folds lane sums, checks the packet and unpacks the fields.
module fspd_merge
  import fspd_pkg::*;
(
  input  fspd_frame_t                 frame,
  input  fspd_lane_t [LANES-1:0]      lanes,
  input  logic [LANES-1:0][7:0]       stored,
  input  logic                        first_half_seen,
  input  logic                        packet_complete,
  output fspd_result_t                result,
  output fspd_ctrl_t                  ctrl
);

  logic [15:0] sum;
  logic [15:0] given;
  logic [15:0] status;
  logic        hdr_ok;

  always_comb begin
    sum    = '0;
    hdr_ok = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      sum    = sum + {7'd0, lanes[i].pair_sum};
      hdr_ok = hdr_ok & lanes[i].hdr_ok;
    end
  end

  assign given  = {frame.frame_byte6, frame.frame_byte7};
  assign status = {stored[6], stored[7]};

  always_comb begin
    result      = '0;
    ctrl        = '0;
    result.result_code = RES_OK;
    if (frame.func) begin
      ctrl.restart = 1'b1;
    end else if (frame.frame_length != FRAME_LEN) begin
      result.result_code = RES_BAD_LEN;
    end else if (packet_complete) begin
      result.result_code = RES_COMPLETE;
    end else if (!first_half_seen) begin
      if (!hdr_ok) begin
        result.result_code = RES_BAD_HDR;
      end else begin
        ctrl.store_first = 1'b1;
      end
    end else begin
      ctrl.set_complete = 1'b1;
      if (sum != given) begin
        result.result_code = RES_BAD_SUM;
      end else begin
        result.packet_ready      = 1'b1;
        result.sample_count      = {stored[4], stored[5]};
        result.sensor_index      = status[2:0];
        result.several_sensors   = status[3];
        result.overload_bits     = status[9:4];
        result.sensor_fault      = status[12:10];
        result.acquisition_fault = status[15:13];
        result.force_x           = {frame.frame_byte0, frame.frame_byte1};
        result.force_y           = {frame.frame_byte2, frame.frame_byte3};
        result.force_z           = {frame.frame_byte4, frame.frame_byte5};
      end
    end
  end

endmodule

[design/force_sensor_frame_pair_decoder_top.sv]
// Frame pair decoder for a 6-axis force sensor (two 8-byte bus frames per packet).
// Takes one frame or restart beat per clock and returns exactly one result beat for
// each, in the cycle after acceptance, from an output register. All eight byte lanes
// and the checksum fold are combinational, so throughput is one beat per cycle;
// frame input stalls only while a finished result is held by result_stall. The
// first-frame store is loaded from an accepted header frame and read only after.
module force_sensor_frame_pair_decoder_top
  import fspd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         frame_valid,
  output logic         frame_stall,
  input  fspd_frame_t  frame,
  output logic         result_valid,
  input  logic         result_stall,
  output fspd_result_t result
);

  logic                  first_half_seen;
  logic                  packet_complete;
  logic [LANES-1:0][7:0] stored;
  logic [LANES-1:0][7:0] frame_bytes;
  fspd_lane_t [LANES-1:0] lanes;
  fspd_result_t          result_next;
  fspd_ctrl_t            ctrl;
  logic                  accept;

  assign frame_stall = result_valid && result_stall;
  assign accept      = frame_valid && !frame_stall;

  assign frame_bytes = {frame.frame_byte7, frame.frame_byte6, frame.frame_byte5,
                        frame.frame_byte4, frame.frame_byte3, frame.frame_byte2,
                        frame.frame_byte1, frame.frame_byte0};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fspd_lane u_lane (
      .cfg         (lane_cfg(g)),
      .stored_byte (stored[g]),
      .frame_byte  (frame_bytes[g]),
      .lane        (lanes[g])
    );
  end

  fspd_merge u_merge (
    .frame           (frame),
    .lanes           (lanes),
    .stored          (stored),
    .first_half_seen (first_half_seen),
    .packet_complete (packet_complete),
    .result          (result_next),
    .ctrl            (ctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_half_seen <= 1'b0;
      packet_complete <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (accept) begin
        result_valid <= 1'b1;
        if (ctrl.restart) begin
          first_half_seen <= 1'b0;
          packet_complete <= 1'b0;
        end
        if (ctrl.store_first) begin
          first_half_seen <= 1'b1;
        end
        if (ctrl.set_complete) begin
          packet_complete <= 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
      if (ctrl.store_first) begin
        stored <= frame_bytes;
      end
    end
  end

`ifndef SYNTH
  a_complete_needs_first: assert property (@(posedge clk) disable iff (rst)
    packet_complete |-> first_half_seen)
    else $error("packet complete without a stored first half");

  a_ready_is_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.packet_ready |-> result.result_code == RES_OK)
    else $error("packet ready with a failure code");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.packet_ready |->
      result.sample_count == 16'd0 && result.force_x == 16'sd0)
    else $error("fields set without a ready packet");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && frame.func |=> !first_half_seen && !packet_complete)
    else $error("restart left assembly flags set");
`endif

endmodule
